### hdl/jms_pkg.sv
// Shared types and constants for the JPEG marker segmenter.
`timescale 1ns / 1ps
`default_nettype none
package jms_pkg;

   // Marker codes and the fill byte
   localparam logic [7:0] BYTE_FF   = 8'hff;
   localparam logic [7:0] CODE_TEM  = 8'h01;
   localparam logic [7:0] CODE_RST0 = 8'hd0;
   localparam logic [7:0] CODE_RST7 = 8'hd7;
   localparam logic [7:0] CODE_SOI  = 8'hd8;
   localparam logic [7:0] CODE_EOI  = 8'hd9;
   localparam logic [7:0] CODE_SOS  = 8'hda;

   // Classification of each byte on the result channel
   typedef enum logic [2:0] {
      KIND_START   = 3'd0,
      KIND_FF      = 3'd1,
      KIND_CODE    = 3'd2,
      KIND_LENGTH  = 3'd3,
      KIND_PAYLOAD = 3'd4,
      KIND_IGNORED = 3'd5
   } kind_type;

   // Sticky fault codes
   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_BAD_START = 2'd1,
      ERR_NO_PREFIX = 2'd2,
      ERR_SHORT_LEN = 2'd3
   } err_type;

   // Parser phase, one-hot
   typedef enum logic [6:0] {
      PH_START0  = 7'b0000001,
      PH_START1  = 7'b0000010,
      PH_PREFIX  = 7'b0000100,
      PH_CODE    = 7'b0001000,
      PH_LENHI   = 7'b0010000,
      PH_LENLO   = 7'b0100000,
      PH_PAYLOAD = 7'b1000000
   } phase_type;

   // One result item
   typedef struct packed {
      kind_type    byte_kind;
      logic [7:0]  marker_code;
      logic [7:0]  payload_byte;
      logic [15:0] payload_offset;
      logic        segment_last;
      logic        stopped;
      err_type     error_code;
   } result_type;

endpackage
`default_nettype wire

### hdl/jms_parse_core.sv
// Per-byte parser state and result logic of the marker segmenter.
`timescale 1ns / 1ps
`default_nettype none
module jms_parse_core
   import jms_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       byte_take,
   input  wire logic [7:0] data_byte,
   output result_type      result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  marker_ff, marker_in;
   logic [7:0]  len_high_ff, len_high_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] count_ff, count_in;
   logic        halted_ff, halted_in;
   err_type     error_ff, error_in;

   kind_type    kind;
   logic [7:0]  pbyte;
   logic [15:0] poff;
   logic        last;
   logic [15:0] seg_len;

   assign seg_len = {len_high_ff, data_byte};

   // Work out the next state and the result for the presented byte
   always_comb begin
      phase_in     = phase_ff;
      marker_in    = marker_ff;
      len_high_in  = len_high_ff;
      remaining_in = remaining_ff;
      count_in     = count_ff;
      halted_in    = halted_ff;
      error_in     = error_ff;
      kind         = KIND_IGNORED;
      pbyte        = 8'd0;
      poff         = 16'd0;
      last         = 1'b0;
      if (!halted_ff && error_ff == ERR_NONE) begin
         case (phase_ff)
            PH_START0: begin
               if (data_byte == BYTE_FF) begin
                  kind     = KIND_START;
                  phase_in = PH_START1;
               end else begin
                  error_in = ERR_BAD_START;
               end
            end
            PH_START1: begin
               if (data_byte == CODE_SOI) begin
                  kind      = KIND_START;
                  marker_in = CODE_SOI;
                  last      = 1'b1;
                  phase_in  = PH_PREFIX;
               end else begin
                  error_in = ERR_BAD_START;
               end
            end
            PH_PREFIX: begin
               if (data_byte == BYTE_FF) begin
                  kind     = KIND_FF;
                  phase_in = PH_CODE;
               end else begin
                  error_in = ERR_NO_PREFIX;
               end
            end
            PH_CODE: begin
               if (data_byte == BYTE_FF) begin
                  kind = KIND_FF;
               end else begin
                  kind      = KIND_CODE;
                  marker_in = data_byte;
                  if (data_byte == CODE_EOI || data_byte == CODE_SOS) begin
                     halted_in = 1'b1;
                     last      = 1'b1;
                  end else if (data_byte inside {CODE_TEM, [CODE_RST0:CODE_RST7]}) begin
                     last     = 1'b1;
                     phase_in = PH_PREFIX;
                  end else begin
                     phase_in = PH_LENHI;
                  end
               end
            end
            PH_LENHI: begin
               kind        = KIND_LENGTH;
               len_high_in = data_byte;
               phase_in    = PH_LENLO;
            end
            PH_LENLO: begin
               if (seg_len < 16'd2) begin
                  error_in = ERR_SHORT_LEN;
               end else begin
                  kind = KIND_LENGTH;
                  if (seg_len == 16'd2) begin
                     last     = 1'b1;
                     phase_in = PH_PREFIX;
                  end else begin
                     remaining_in = seg_len - 16'd2;
                     count_in     = 16'd0;
                     phase_in     = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               kind         = KIND_PAYLOAD;
               pbyte        = data_byte;
               poff         = count_ff;
               count_in     = count_ff + 16'd1;
               remaining_in = remaining_ff - 16'd1;
               if (remaining_ff == 16'd1) begin
                  last     = 1'b1;
                  phase_in = PH_PREFIX;
               end
            end
            default: begin
               kind = KIND_IGNORED;
            end
         endcase
      end
   end

   // Advance the state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START0;
         marker_ff    <= 8'd0;
         len_high_ff  <= 8'd0;
         remaining_ff <= 16'd0;
         count_ff     <= 16'd0;
         halted_ff    <= 1'b0;
         error_ff     <= ERR_NONE;
      end else if (byte_take) begin
         phase_ff     <= phase_in;
         marker_ff    <= marker_in;
         len_high_ff  <= len_high_in;
         remaining_ff <= remaining_in;
         count_ff     <= count_in;
         halted_ff    <= halted_in;
         error_ff     <= error_in;
      end
   end

   // Report the state after this byte
   always_comb begin
      result.byte_kind      = kind;
      result.marker_code    = marker_in;
      result.payload_byte   = pbyte;
      result.payload_offset = poff;
      result.segment_last   = last;
      result.stopped        = halted_in;
      result.error_code     = error_in;
   end

`ifndef ASSERT_OFF
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      error_ff != ERR_NONE |=> error_ff == $past(error_ff))
      else $error("sticky error code changed");
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff && phase_ff == $past(phase_ff))
      else $error("parser left the stopped state");
   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> remaining_ff != 16'd0)
      else $error("payload phase with nothing left to read");
`endif

endmodule
`default_nettype wire

### hdl/jms_result_buf.sv
// Two-entry output register with skid stage for the result channel.
`timescale 1ns / 1ps
`default_nettype none
module jms_result_buf
   import jms_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire result_type  push_data,
   output logic             push_ready,
   output logic             out_valid,
   input  wire logic        out_ready,
   output result_type       out_data
);

   logic       main_valid_ff, skid_valid_ff;
   result_type main_ff, skid_ff;
   logic       pop;

   assign pop        = main_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;

   // Hold flags for the output and skid stages
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end
         main_valid_ff <= 1'b1;
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   // Move payload: skid drains into the output stage first
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_ff <= push_data;
         end else begin
            skid_ff <= push_data;
         end
      end
   end

`ifndef ASSERT_OFF
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid stage full while output stage empty");
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pop |=> main_valid_ff && main_ff == $past(skid_ff))
      else $error("skid entry lost on drain");
`endif

endmodule
`default_nettype wire

### hdl/jpeg_marker_segmenter_top.sv
// Top level of the JPEG marker segmenter: byte parser and result buffer.
//
//   channel | ports                          | direction | transfer
//   --------+--------------------------------+-----------+----------------------
//   req     | req_valid/ready, req_data_byte | in        | one file byte
//   rsp     | rsp_valid/ready, rsp_* fields  | out       | one result per byte
//
// One byte a cycle while req_ready is high: the parser state updates in the cycle
// of the transfer and the result is registered into the output or skid stage.
// A two-entry output register and skid stage keep req_ready high while one
// result waits; req_ready falls only when both entries are full.
// Synchronous reset returns the parser to the first start byte and empties
// the buffer.
`timescale 1ns / 1ps
`default_nettype none
module jpeg_marker_segmenter_top
   import jms_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_byte_kind,
   output logic [7:0]       rsp_marker_code,
   output logic [7:0]       rsp_payload_byte,
   output logic [15:0]      rsp_payload_offset,
   output logic             rsp_segment_last,
   output logic             rsp_stopped,
   output logic [1:0]       rsp_error_code
);

   logic       take;
   result_type core_result;
   result_type out_result;

   assign take = req_valid && req_ready;

   jms_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .byte_take (take),
      .data_byte (req_data_byte),
      .result    (core_result)
   );

   jms_result_buf u_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (take),
      .push_data  (core_result),
      .push_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_result)
   );

   // Unpack the result onto the field ports
   assign rsp_byte_kind      = out_result.byte_kind;
   assign rsp_marker_code    = out_result.marker_code;
   assign rsp_payload_byte   = out_result.payload_byte;
   assign rsp_payload_offset = out_result.payload_offset;
   assign rsp_segment_last   = out_result.segment_last;
   assign rsp_stopped        = out_result.stopped;
   assign rsp_error_code     = out_result.error_code;

endmodule
`default_nettype wire
